FILE: rtl/core/lj_pkg.sv
// Shared types, constants and helpers of the Lennard-Jones pair engine.
`default_nettype none
package lj_pkg;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] neighbour_x;
    logic signed [31:0] neighbour_y;
    logic signed [31:0] neighbour_z;
    logic               pair_present;
    logic               last_neighbour;
    logic               first_atom;
  } pair_in_t;

  typedef struct packed {
    logic signed [47:0] atom_energy;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] total_energy;
  } pair_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [62:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [63:0] den;
    logic [6:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [62:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

  localparam logic [62:0] CAP62 = 63'h4000_0000_0000_0000;
  localparam logic [62:0] ONE_Q32 = 63'h0000_0001_0000_0000;

  localparam logic [2:0] CFG_SIGMA   = 3'd0;
  localparam logic [2:0] CFG_EPSILON = 3'd1;
  localparam logic [2:0] CFG_CUTOFF  = 3'd2;
  localparam logic [2:0] CFG_SHIFT   = 3'd3;
  localparam logic [2:0] CFG_BOX_X   = 3'd4;
  localparam logic [2:0] CFG_BOX_Y   = 3'd5;
  localparam logic [2:0] CFG_BOX_Z   = 3'd6;

  localparam logic [6:0] MOD_ITERS = 7'd33;
  localparam logic [6:0] DIV_ITERS = 7'd96;

  localparam logic [5:0] SH_Q32  = 6'd32;
  localparam logic [5:0] SH_EPS  = 6'd22;
  localparam logic [5:0] SH_FEPS = 6'd16;
  localparam logic [5:0] SH_FRC  = 6'd24;
  localparam logic [5:0] SH_NONE = 6'd0;

  localparam logic signed [65:0] MAX48 = 66'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] MIN48 = -66'sh0_8000_0000_0000;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > MAX48) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < MIN48) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [65:0] sx48(input logic signed [47:0] v);
    return {{18{v[47]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lj_pair_energy_force.sv
// Top level of the Lennard-Jones 12-6 truncated and shifted pair engine.
// One pair transaction is taken at a time. A transaction without a pair goes straight
// to the finish state; a pair has each wrapped axis reduced by a 33-step bit-serial
// remainder against the box length, then takes 15 products on the shared four-part
// multiplier and two 96-step quotients on the shared divider.
// The last neighbour of an atom loads the output register, which holds while stalled;
// the next pair transaction is accepted meanwhile.
`default_nettype none
module lj_pair_energy_force import lj_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  pair_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pair_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_WRAP_GO   = 6'b000010,
    ST_WRAP_WAIT = 6'b000100,
    ST_RUN_GO    = 6'b001000,
    ST_RUN_WAIT  = 6'b010000,
    ST_FINISH    = 6'b100000
  } state_t;

  typedef enum logic [16:0] {
    S_RX = 17'h00001, S_RY = 17'h00002, S_RZ = 17'h00004, S_RC = 17'h00008,
    S_SG = 17'h00010, S_S2 = 17'h00020, S_S4 = 17'h00040, S_S6 = 17'h00080,
    S_P  = 17'h00100, S_E  = 17'h00200, S_G  = 17'h00400, S_H  = 17'h00800,
    S_K  = 17'h01000, S_C  = 17'h02000, S_FX = 17'h04000, S_FY = 17'h08000,
    S_FZ = 17'h10000
  } step_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  state_t state;
  step_t  step;

  logic [30:0]        sigma_len;
  logic [30:0]        epsilon_energy;
  logic [30:0]        cutoff_radius;
  logic signed [31:0] energy_shift;
  logic [30:0]        box_x;
  logic [30:0]        box_y;
  logic [30:0]        box_z;

  pair_in_t           item;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] dz;
  logic [1:0]         axis;
  logic               far;
  logic [63:0]        r2;
  logic [62:0]        s2;
  logic [62:0]        s6;
  logic [62:0]        t;
  logic signed [47:0] energy_sum;
  logic signed [47:0] force_sum_x;
  logic signed [47:0] force_sum_y;
  logic signed [47:0] force_sum_z;
  logic signed [47:0] grand_total;
  pair_out_t          out_reg;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [32:0] d_cur;
  logic [30:0]        box_cur;
  logic [32:0]        m_fold;
  logic signed [32:0] d_fold;
  logic signed [32:0] d_new;
  logic               far_now;
  logic               is_div;
  logic               a_neg;
  logic [63:0]        a_mag;
  logic               b_neg;
  logic [63:0]        b_mag;
  logic [63:0]        s6x2;
  logic signed [32:0] d_step;
  logic signed [65:0] pe;
  logic signed [47:0] pe_sat;
  logic signed [47:0] f_sat;
  logic               f_neg;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall = state != ST_IDLE;
  assign out_free = !out_valid || !out_stall;
  assign out_data = out_reg;

  always_comb begin
    unique case (axis)
      2'd1: begin d_cur = dy; box_cur = box_y; end
      2'd2: begin d_cur = dz; box_cur = box_z; end
      default: begin d_cur = dx; box_cur = box_x; end
    endcase
    if (d_cur[32] && drsp.rem[30:0] != 31'd0) begin
      m_fold = {2'b0, box_cur} - {2'b0, drsp.rem[30:0]};
    end else begin
      m_fold = {2'b0, drsp.rem[30:0]};
    end
    if ({m_fold[31:0], 1'b0} > {2'b0, box_cur}) begin
      d_fold = $signed(m_fold - {2'b0, box_cur});
    end else begin
      d_fold = $signed(m_fold);
    end
    d_new = (state == ST_WRAP_WAIT) ? d_fold : d_cur;
    far_now = mag33(d_new) >= {2'b0, cutoff_radius};

    s6x2 = {s6, 1'b0};
    a_neg = s6 < ONE_Q32;
    a_mag = a_neg ? 64'({1'b0, ONE_Q32} - {1'b0, s6}) : 64'({1'b0, s6} - {1'b0, ONE_Q32});
    b_neg = s6x2 < {1'b0, ONE_Q32};
    b_mag = b_neg ? ({1'b0, ONE_Q32} - s6x2) : (s6x2 - {1'b0, ONE_Q32});

    is_div = step == S_S2 || step == S_H;
    unique case (step)
      S_RY, S_FY: d_step = dy;
      S_RZ, S_FZ: d_step = dz;
      default: d_step = dx;
    endcase

    pe = (a_neg ? -$signed({3'b0, mrsp.res}) : $signed({3'b0, mrsp.res}))
         - $signed({{26{energy_shift[31]}}, energy_shift, 8'd0});
    pe_sat = sat48(pe);
    f_neg = b_neg ^ d_step[32];
    f_sat = sat48(f_neg ? -$signed({3'b0, mrsp.res}) : $signed({3'b0, mrsp.res}));
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.a = 64'd0;
    mreq.b = 64'd0;
    mreq.sh = SH_NONE;
    dreq.start = 1'b0;
    dreq.dividend = {1'b0, t, 32'd0};
    dreq.den = r2;
    dreq.iters = DIV_ITERS;
    if (state == ST_WRAP_GO) begin
      dreq.start = box_cur != 31'd0;
      dreq.dividend = {mag33(d_cur), 63'd0};
      dreq.den = {33'd0, box_cur};
      dreq.iters = MOD_ITERS;
    end else if (state == ST_RUN_GO) begin
      dreq.start = is_div;
      mreq.start = !is_div;
      unique case (step)
        S_RX, S_RY, S_RZ: begin
          mreq.a = {31'd0, mag33(d_step)};
          mreq.b = {31'd0, mag33(d_step)};
        end
        S_RC: begin
          mreq.a = {33'd0, cutoff_radius};
          mreq.b = {33'd0, cutoff_radius};
        end
        S_SG: begin
          mreq.a = {33'd0, sigma_len};
          mreq.b = {33'd0, sigma_len};
        end
        S_S4: begin mreq.a = {1'b0, s2}; mreq.b = {1'b0, s2}; mreq.sh = SH_Q32; end
        S_S6: begin mreq.a = {1'b0, t};  mreq.b = {1'b0, s2}; mreq.sh = SH_Q32; end
        S_P:  begin mreq.a = {1'b0, s6}; mreq.b = a_mag; mreq.sh = SH_Q32; end
        S_E: begin
          mreq.a = {1'b0, t};
          mreq.b = {33'd0, epsilon_energy};
          mreq.sh = SH_EPS;
        end
        S_G:  begin mreq.a = {1'b0, s6}; mreq.b = b_mag; mreq.sh = SH_Q32; end
        S_K: begin
          mreq.a = {1'b0, t};
          mreq.b = {33'd0, epsilon_energy};
          mreq.sh = SH_FEPS;
        end
        S_C:  begin mreq.a = {1'b0, t}; mreq.b = 64'd24; mreq.sh = SH_NONE; end
        S_FX, S_FY, S_FZ: begin
          mreq.a = {1'b0, t};
          mreq.b = {31'd0, mag33(d_step)};
          mreq.sh = SH_FRC;
        end
        default: begin
          mreq.a = 64'd0;
          mreq.b = 64'd0;
        end
      endcase
    end
  end

  lj_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  lj_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_len <= 31'd222822;
      epsilon_energy <= 31'd682;
      cutoff_radius <= 31'd557056;
      energy_shift <= 32'sd0;
      box_x <= 31'd655360;
      box_y <= 31'd655360;
      box_z <= 31'd655360;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIGMA:   sigma_len <= cfg_data[30:0];
        CFG_EPSILON: epsilon_energy <= cfg_data[30:0];
        CFG_CUTOFF:  cutoff_radius <= cfg_data[30:0];
        CFG_SHIFT:   energy_shift <= $signed(cfg_data);
        CFG_BOX_X:   box_x <= cfg_data[30:0];
        CFG_BOX_Y:   box_y <= cfg_data[30:0];
        CFG_BOX_Z:   box_z <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= S_RX;
      axis <= 2'd0;
      far <= 1'b0;
      out_valid <= 1'b0;
      energy_sum <= 48'sd0;
      force_sum_x <= 48'sd0;
      force_sum_y <= 48'sd0;
      force_sum_z <= 48'sd0;
      grand_total <= 48'sd0;
    end else begin
      if (out_valid && !out_stall && !(state == ST_FINISH && item.last_neighbour)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            dx <= 33'(in_data.center_x) - 33'(in_data.neighbour_x);
            dy <= 33'(in_data.center_y) - 33'(in_data.neighbour_y);
            dz <= 33'(in_data.center_z) - 33'(in_data.neighbour_z);
            axis <= 2'd0;
            far <= 1'b0;
            if (in_data.first_atom) begin
              grand_total <= 48'sd0;
            end
            state <= in_data.pair_present ? ST_WRAP_GO : ST_FINISH;
          end
        end
        ST_WRAP_GO, ST_WRAP_WAIT: begin
          if (state == ST_WRAP_WAIT || box_cur == 31'd0) begin
            if (state == ST_WRAP_GO || drsp.done) begin
              unique case (axis)
                2'd1: dy <= d_new;
                2'd2: dz <= d_new;
                default: dx <= d_new;
              endcase
              far <= far | far_now;
              if (axis == 2'd2) begin
                step <= S_RX;
                state <= (far || far_now) ? ST_FINISH : ST_RUN_GO;
              end else begin
                axis <= axis + 2'd1;
                state <= ST_WRAP_GO;
              end
            end
          end else begin
            state <= ST_WRAP_WAIT;
          end
        end
        ST_RUN_GO: begin
          state <= ST_RUN_WAIT;
        end
        ST_RUN_WAIT: begin
          if (is_div ? drsp.done : mrsp.done) begin
            state <= ST_RUN_GO;
            unique case (step)
              S_RX: begin r2 <= {1'b0, mrsp.res}; step <= S_RY; end
              S_RY: begin r2 <= r2 + {1'b0, mrsp.res}; step <= S_RZ; end
              S_RZ: begin r2 <= r2 + {1'b0, mrsp.res}; step <= S_RC; end
              S_RC: begin
                if (r2 >= {1'b0, mrsp.res} || r2 == 64'd0) begin
                  state <= ST_FINISH;
                end
                step <= S_SG;
              end
              S_SG: begin t <= mrsp.res; step <= S_S2; end
              S_S2: begin s2 <= drsp.quo; step <= S_S4; end
              S_S4: begin t <= mrsp.res; step <= S_S6; end
              S_S6: begin s6 <= mrsp.res; step <= S_P; end
              S_P:  begin t <= mrsp.res; step <= S_E; end
              S_E: begin
                energy_sum <= sat48(sx48(energy_sum) + sx48(pe_sat));
                step <= S_G;
              end
              S_G:  begin t <= mrsp.res; step <= S_H; end
              S_H:  begin t <= drsp.quo; step <= S_K; end
              S_K:  begin t <= mrsp.res; step <= S_C; end
              S_C:  begin t <= mrsp.res; step <= S_FX; end
              S_FX: begin
                force_sum_x <= sat48(sx48(force_sum_x) + sx48(f_sat));
                step <= S_FY;
              end
              S_FY: begin
                force_sum_y <= sat48(sx48(force_sum_y) + sx48(f_sat));
                step <= S_FZ;
              end
              S_FZ: begin
                force_sum_z <= sat48(sx48(force_sum_z) + sx48(f_sat));
                state <= ST_FINISH;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_FINISH: begin
          if (!item.last_neighbour) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_reg.atom_energy <= energy_sum;
            out_reg.force_x <= force_sum_x;
            out_reg.force_y <= force_sum_y;
            out_reg.force_z <= force_sum_z;
            out_reg.total_energy <= sat48(sx48(grand_total) + sx48(energy_sum));
            grand_total <= sat48(sx48(grand_total) + sx48(energy_sum));
            energy_sum <= 48'sd0;
            force_sum_x <= 48'sd0;
            force_sum_y <= 48'sd0;
            force_sum_z <= 48'sd0;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lj_mul.sv
// Multi-cycle 64x64 multiplier from 32x32 partial products, shift and saturate.
`default_nettype none
module lj_mul import lj_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [5:0]   sh;
  logic [2:0]   ph;
  logic [63:0]  prod;
  logic [6:0]   poff;
  logic [127:0] acc;
  logic [62:0]  res;
  logic         done;
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [6:0]   moff;
  logic [127:0] shifted;
  logic         cap;

  always_comb begin
    ma = 32'd0;
    mb = 32'd0;
    moff = 7'd0;
    unique case (ph)
      3'd1: begin ma = a[31:0];  mb = b[31:0];  moff = 7'd0;  end
      3'd2: begin ma = a[63:32]; mb = b[31:0];  moff = 7'd32; end
      3'd3: begin ma = a[31:0];  mb = b[63:32]; moff = 7'd32; end
      3'd4: begin ma = a[63:32]; mb = b[63:32]; moff = 7'd64; end
      default: begin ma = 32'd0; mb = 32'd0; moff = 7'd0; end
    endcase
    shifted = acc >> sh;
    cap = shifted > {65'd0, CAP62};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ph <= 3'd1;
      end else if (ph == 3'd6) begin
        ph <= 3'd0;
        done <= 1'b1;
      end else if (ph != 3'd0) begin
        ph <= ph + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
      sh <= req.sh;
      acc <= 128'd0;
    end else begin
      if (ph >= 3'd1 && ph <= 3'd4) begin
        prod <= ma * mb;
        poff <= moff;
      end
      if (ph >= 3'd2 && ph <= 3'd5) begin
        acc <= acc + ({64'd0, prod} << poff);
      end
      if (ph == 3'd6) begin
        res <= cap ? CAP62 : shifted[62:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res = res;

endmodule
`default_nettype wire

FILE: rtl/core/lj_div.sv
// Bit-serial restoring divider: capped Q31.32 quotient and remainder.
`default_nettype none
module lj_div import lj_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [95:0] dvd;
  logic [63:0] den;
  logic [63:0] rem;
  logic [62:0] q;
  logic        ovf;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, dvd[95]};
    diff = trial - {1'b0, den};
    ge = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      den <= req.den;
      rem <= 64'd0;
      q <= 63'd0;
      ovf <= 1'b0;
      cnt <= req.iters;
    end else if (busy) begin
      dvd <= {dvd[94:0], 1'b0};
      rem <= ge ? diff[63:0] : trial[63:0];
      q <= {q[61:0], ge};
      ovf <= ovf | q[62];
      cnt <= cnt - 7'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo = (ovf || q > CAP62) ? CAP62 : q;
  assign rsp.rem = rem;

endmodule
`default_nettype wire
